/* src/qfb_pkg.sv */
// Shared definitions for the quantile feature binner.
// Holds default widths, register index codes and the divider control structs.
// No dependencies.
package qfb_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int INDEX_WIDTH_DEF = 24;
   localparam int BIN_WIDTH_DEF   = 16;

   // register index codes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COL_ROWS  = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIN_LIMIT = 1'b1;

   localparam int COL_ROWS_RESET  = 1;
   localparam int BIN_LIMIT_RESET = 256;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* src/qfb_divider.sv */
// Restoring divider, one quotient bit per cycle through one shared subtract/compare.
// Depends on qfb_pkg (control and status structs).
module qfb_divider #(
   parameter int INDEX_WIDTH = qfb_pkg::INDEX_WIDTH_DEF,
   parameter int BIN_WIDTH   = qfb_pkg::BIN_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qfb_pkg::div_ctrl_type    ctrl,
   input  logic [INDEX_WIDTH-1:0]   dividend,
   input  logic [BIN_WIDTH-1:0]     divisor,
   output qfb_pkg::div_stat_type    stat,
   output logic [INDEX_WIDTH-1:0]   quotient,
   output logic [BIN_WIDTH-1:0]     remainder
);
   import qfb_pkg::*;

   localparam int CNT_WIDTH = (INDEX_WIDTH > 1) ? $clog2(INDEX_WIDTH) : 1;
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(INDEX_WIDTH - 1);

   logic [INDEX_WIDTH-1:0] quot_ff, quot_in;
   logic [BIN_WIDTH-1:0]   rem_ff, rem_in;
   logic [BIN_WIDTH-1:0]   div_ff, div_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [BIN_WIDTH:0]     trial;
   logic                   fits;

   // shared unit: shift in next dividend bit, compare and subtract
   assign trial = {rem_ff, quot_ff[INDEX_WIDTH-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[INDEX_WIDTH-2:0], fits};
         rem_in  = fits ? BIN_WIDTH'(trial - {1'b0, div_ff}) : trial[BIN_WIDTH-1:0];
         cnt_in  = cnt_ff + CNT_WIDTH'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

/* src/quantile_feature_binner.sv */
// Quantile feature binner top level: sequencer, pass state and result register.
// Depends on qfb_pkg and qfb_divider.
// Each item is taken in S_IDLE and written to the result register in S_EXEC, which holds
// while the result register is full; the first item of a pass first waits in S_DIV, where
// the serial divider takes one quotient bit a cycle.
// The sequencer takes a new item only once the last one has left S_EXEC.
// Reset: synchronous, active high; clears the pass state, sets the column row count to 1
// and the bin limit to 256, and empties the result register.
module quantile_feature_binner #(
   parameter int VALUE_WIDTH = qfb_pkg::VALUE_WIDTH_DEF,
   parameter int INDEX_WIDTH = qfb_pkg::INDEX_WIDTH_DEF,
   parameter int BIN_WIDTH   = qfb_pkg::BIN_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration writes
   input  logic                                  csr_we,
   input  logic [qfb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [((INDEX_WIDTH > BIN_WIDTH) ? INDEX_WIDTH : BIN_WIDTH)-1:0] csr_wdata,
   // sorted values in
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [VALUE_WIDTH-1:0]         req_value,
   input  logic [INDEX_WIDTH-1:0]                req_row_index,
   // binned rows out
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [INDEX_WIDTH-1:0]                rsp_row_index_res,
   output logic [BIN_WIDTH-1:0]                  rsp_bin,
   output logic                                  rsp_new_border,
   output logic signed [VALUE_WIDTH-1:0]         rsp_border_value,
   output logic [BIN_WIDTH-1:0]                  rsp_border_count,
   output logic                                  rsp_last
);
   import qfb_pkg::*;

   localparam int CW = (INDEX_WIDTH > BIN_WIDTH) ? INDEX_WIDTH : BIN_WIDTH;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [INDEX_WIDTH-1:0] col_rows_ff;
   logic [BIN_WIDTH-1:0]   bin_limit_ff;

   // captured input beat
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [INDEX_WIDTH-1:0]        row_ff, row_in;

   // pass state
   logic [INDEX_WIDTH-1:0] position_ff, position_in;
   logic [BIN_WIDTH-1:0]   slot_ff, slot_in;
   logic [INDEX_WIDTH-1:0] nbp_ff, nbp_in;
   logic [INDEX_WIDTH-1:0] quot_ff, quot_in;
   logic [BIN_WIDTH-1:0]   rem_ff, rem_in;
   logic [BIN_WIDTH-1:0]   distinct_ff, distinct_in;
   logic signed [VALUE_WIDTH-1:0] newest_ff, newest_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [INDEX_WIDTH-1:0]        rsp_row_ff, rsp_row_in;
   logic [BIN_WIDTH-1:0]          rsp_bin_ff, rsp_bin_in;
   logic                          rsp_newb_ff, rsp_newb_in;
   logic signed [VALUE_WIDTH-1:0] rsp_bval_ff, rsp_bval_in;
   logic [BIN_WIDTH-1:0]          rsp_count_ff, rsp_count_in;
   logic                          rsp_last_ff, rsp_last_in;

   // effective row and bin counts, a zero register counts as one and bins are capped at rows
   logic [INDEX_WIDTH-1:0] eff_rows;
   logic [BIN_WIDTH-1:0]   bins_nz;
   logic [CW-1:0]          eff_bins_wide;
   logic [BIN_WIDTH-1:0]   eff_bins;

   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;
   logic [INDEX_WIDTH-1:0] div_quot;
   logic [BIN_WIDTH-1:0]   div_rem;

   // working signals of the execute step
   logic                   have_border;
   logic                   same_value;
   logic                   on_border;
   logic                   is_last;
   logic [BIN_WIDTH-1:0]   slot_next;
   logic [BIN_WIDTH:0]     slot_sum;
   logic [INDEX_WIDTH-1:0] step_next;
   logic                   first_extra;

   assign eff_rows      = (col_rows_ff == '0) ? INDEX_WIDTH'(1) : col_rows_ff;
   assign bins_nz       = (bin_limit_ff == '0) ? BIN_WIDTH'(1) : bin_limit_ff;
   assign eff_bins_wide = (CW'(bins_nz) < CW'(eff_rows)) ? CW'(bins_nz) : CW'(eff_rows);
   assign eff_bins      = eff_bins_wide[BIN_WIDTH-1:0];

   qfb_divider #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .BIN_WIDTH   (BIN_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (eff_rows),
      .divisor   (eff_bins),
      .stat      (div_stat),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // the first border of a pass gets one extra row when the remainder reaches
   // the bin count at slot zero
   assign first_extra = {1'b0, div_rem} >= {1'b0, eff_bins};

   assign have_border = distinct_ff != '0;
   assign same_value  = have_border && (value_ff == newest_ff);
   assign on_border   = position_ff == nbp_ff;
   assign is_last     = position_ff == (eff_rows - INDEX_WIDTH'(1));
   assign slot_next   = slot_ff + BIN_WIDTH'(1);
   assign slot_sum    = {1'b0, slot_next} + {1'b0, rem_ff};
   assign step_next   = quot_ff + INDEX_WIDTH'(slot_sum >= {1'b0, eff_bins});

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      row_in       = row_ff;
      position_in  = position_ff;
      slot_in      = slot_ff;
      nbp_in       = nbp_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      distinct_in  = distinct_ff;
      newest_in    = newest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_newb_in  = rsp_newb_ff;
      rsp_bval_in  = rsp_bval_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      div_ctrl     = '0;

      unique case (state_ff)
         S_IDLE: begin
            // take the beat; the first row of a pass needs quotient and remainder
            if (req_valid) begin
               value_in = req_value;
               row_in   = req_row_index;
               if (position_ff == '0) begin
                  div_ctrl.start = 1'b1;
                  state_in       = S_DIV;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_DIV: begin
            // latch the division and place the first border
            if (div_stat.done) begin
               quot_in  = div_quot;
               rem_in   = div_rem;
               slot_in  = '0;
               nbp_in   = div_quot + INDEX_WIDTH'(first_extra) - INDEX_WIDTH'(1);
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_bin_in   = same_value ? distinct_ff - BIN_WIDTH'(1) : distinct_ff;
               rsp_newb_in  = 1'b0;
               rsp_bval_in  = '0;
               rsp_count_in = distinct_ff;
               if (on_border) begin
                  if (!same_value) begin
                     newest_in    = value_ff;
                     distinct_in  = distinct_ff + BIN_WIDTH'(1);
                     rsp_newb_in  = 1'b1;
                     rsp_bval_in  = value_ff;
                     rsp_count_in = distinct_ff + BIN_WIDTH'(1);
                  end
                  slot_in = slot_next;
                  nbp_in  = nbp_ff + step_next;
               end
               rsp_last_in = is_last;
               if (is_last) begin
                  // end of column: drop all pass state
                  position_in = '0;
                  slot_in     = '0;
                  nbp_in      = '0;
                  quot_in     = '0;
                  rem_in      = '0;
                  distinct_in = '0;
                  newest_in   = '0;
               end else begin
                  position_in = position_ff + INDEX_WIDTH'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_rows_ff  <= INDEX_WIDTH'(COL_ROWS_RESET);
         bin_limit_ff <= BIN_WIDTH'(BIN_LIMIT_RESET);
         position_ff  <= '0;
         slot_ff      <= '0;
         nbp_ff       <= '0;
         quot_ff      <= '0;
         rem_ff       <= '0;
         distinct_ff  <= '0;
         newest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         position_ff  <= position_in;
         slot_ff      <= slot_in;
         nbp_ff       <= nbp_in;
         quot_ff      <= quot_in;
         rem_ff       <= rem_in;
         distinct_ff  <= distinct_in;
         newest_ff    <= newest_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_COL_ROWS:  col_rows_ff  <= csr_wdata[INDEX_WIDTH-1:0];
               CSR_BIN_LIMIT: bin_limit_ff <= csr_wdata[BIN_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      value_ff     <= value_in;
      row_ff       <= row_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_newb_ff  <= rsp_newb_in;
      rsp_bval_ff  <= rsp_bval_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row_index_res = rsp_row_ff;
   assign rsp_bin           = rsp_bin_ff;
   assign rsp_new_border    = rsp_newb_ff;
   assign rsp_border_value  = rsp_bval_ff;
   assign rsp_border_count  = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* src/qfb_checker.sv */
// Port-level checks for the quantile feature binner, bound to the top level.
// Depends on qfb_pkg and quantile_feature_binner.
module qfb_checker #(
   parameter int VALUE_WIDTH = qfb_pkg::VALUE_WIDTH_DEF,
   parameter int INDEX_WIDTH = qfb_pkg::INDEX_WIDTH_DEF,
   parameter int BIN_WIDTH   = qfb_pkg::BIN_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [INDEX_WIDTH-1:0]        rsp_row_index_res,
   input logic [BIN_WIDTH-1:0]          rsp_bin,
   input logic                          rsp_new_border,
   input logic signed [VALUE_WIDTH-1:0] rsp_border_value,
   input logic [BIN_WIDTH-1:0]          rsp_border_count
);
   import qfb_pkg::*;

   // no beat may be shown straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // a stalled beat holds its row, bin and border count
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_index_res)
         && $stable(rsp_bin) && $stable(rsp_border_count))
      else $error("stalled result beat changed");

   // a row that opens a border takes that border's index
   a_new_border_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_border |-> rsp_bin == rsp_border_count - BIN_WIDTH'(1))
      else $error("new border row not in the newest bin");

   // border value is zero unless a border opened
   a_border_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_new_border |-> rsp_border_value == '0)
      else $error("border value set without a new border");

endmodule

bind quantile_feature_binner qfb_checker #(
   .VALUE_WIDTH (VALUE_WIDTH),
   .INDEX_WIDTH (INDEX_WIDTH),
   .BIN_WIDTH   (BIN_WIDTH)
) u_qfb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_row_index_res (rsp_row_index_res),
   .rsp_bin           (rsp_bin),
   .rsp_new_border    (rsp_new_border),
   .rsp_border_value  (rsp_border_value),
   .rsp_border_count  (rsp_border_count)
);

/* test/tb_quantile_feature_binner.sv */
// Self-checking testbench for quantile_feature_binner: directed table, random column passes.
// Depends on qfb_pkg and the binner RTL; the binning rule is predicted here in SystemVerilog.
`timescale 1ns / 1ps

module tb_quantile_feature_binner;

   localparam int VW = qfb_pkg::VALUE_WIDTH_DEF;
   localparam int IW = qfb_pkg::INDEX_WIDTH_DEF;
   localparam int BW = qfb_pkg::BIN_WIDTH_DEF;
   localparam int CW = (IW > BW) ? IW : BW;
   localparam int XW = qfb_pkg::CSR_INDEX_WIDTH;

   // A random phase starts no new pass once this many beats are sent: the pass in progress is finished.
   localparam int ROWS_PER_PHASE = 332;
   // Cycles to wait after the last beat before any missing beat is reported.
   localparam int TAIL_CYCLES = IW + 16;
   localparam int REPORT_CAP = 40;

   // One binned row as it leaves the block.
   typedef struct packed {
      logic [IW-1:0]        row_index;
      logic [BW-1:0]        bin;
      logic                 new_border;
      logic signed [VW-1:0] border_value;
      logic [BW-1:0]        border_count;
      logic                 last;
   } bin_beat_type;

   typedef enum logic [0:0] {STEP_ROW, STEP_CSR} plan_kind_type;

   // One row of the directed table: a sorted value to send, or a register write.
   typedef struct packed {
      plan_kind_type        kind;
      logic [XW-1:0]        csr_sel;
      logic [CW-1:0]        csr_data;
      logic signed [VW-1:0] value;
      logic [IW-1:0]        row_index;
      logic                 typed;
      bin_beat_type         beat;
   } plan_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we = 1'b0;
   logic [XW-1:0]        csr_index = '0;
   logic [CW-1:0]        csr_wdata = '0;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [VW-1:0] req_value = '0;
   logic [IW-1:0]        req_row_index = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [IW-1:0]        rsp_row_index_res;
   logic [BW-1:0]        rsp_bin;
   logic                 rsp_new_border;
   logic signed [VW-1:0] rsp_border_value;
   logic [BW-1:0]        rsp_border_count;
   logic                 rsp_last;

   quantile_feature_binner DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .req_row_index     (req_row_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row_index_res (rsp_row_index_res),
      .rsp_bin           (rsp_bin),
      .rsp_new_border    (rsp_new_border),
      .rsp_border_value  (rsp_border_value),
      .rsp_border_count  (rsp_border_count),
      .rsp_last          (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Shadow copy of the registers and the pass state, advanced once per accepted row.
   // ---------------------------------------------------------------------------------------
   logic [IW-1:0]        cfg_rows      = IW'(qfb_pkg::COL_ROWS_RESET);
   logic [BW-1:0]        cfg_bin_limit = BW'(qfb_pkg::BIN_LIMIT_RESET);

   logic [IW-1:0]        row_pos      = '0;
   logic [BW-1:0]        cut_slot     = '0;
   logic [IW-1:0]        next_cut     = '0;
   logic [IW-1:0]        cut_quot     = '0;
   logic [BW-1:0]        cut_rem      = '0;
   logic [BW-1:0]        border_total = '0;
   logic signed [VW-1:0] last_border  = '0;

   bin_beat_type pending_bins[$];

   int  send_idle_pct = 30;
   int  stall_pct     = 30;
   bit  req_high      = 1'b0;
   int  mismatches    = 0;
   int  rows_sent     = 0;
   int  passes_seen   = 0;
   int  borders_seen  = 0;
   int  csr_writes    = 0;

   // A zero register counts as one.
   function automatic logic [IW-1:0] rows_live();
      return (cfg_rows == '0) ? IW'(1) : cfg_rows;
   endfunction

   function automatic logic [IW-1:0] bins_live();
      logic [IW-1:0] cap;
      cap = (cfg_bin_limit == '0) ? IW'(1) : IW'(cfg_bin_limit);
      return (cap < rows_live()) ? cap : rows_live();
   endfunction

   // Distance to the next quantile cut: the quotient, plus one once the remainder threshold
   // is crossed. Sums wrap at the index width, as the positions do.
   function automatic logic [IW-1:0] cut_step();
      logic [31:0] level;
      level = 32'(cut_slot) + 32'(cut_rem);
      return cut_quot + ((level >= 32'(bins_live())) ? IW'(1) : IW'(0));
   endfunction

   function automatic bin_beat_type bin_row(input logic signed [VW-1:0] v,
                                            input logic [IW-1:0] r);
      bin_beat_type beat;
      bit           seen;
      seen = (border_total != '0);
      // first row of a pass latches quotient and remainder
      if (row_pos == '0) begin
         cut_quot = rows_live() / bins_live();
         cut_rem  = BW'(rows_live() % bins_live());
         cut_slot = '0;
         next_cut = cut_step() - IW'(1);
      end
      beat = '0;
      beat.row_index = r;
      beat.bin = (seen && v == last_border) ? border_total - BW'(1) : border_total;
      if (row_pos == next_cut) begin
         // keep only distinct borders
         if (!seen || v != last_border) begin
            last_border       = v;
            border_total      = border_total + BW'(1);
            beat.new_border   = 1'b1;
            beat.border_value = v;
         end
         cut_slot = cut_slot + BW'(1);
         next_cut = next_cut + cut_step();
      end
      beat.last         = (row_pos == rows_live() - IW'(1));
      beat.border_count = border_total;
      if (beat.last) begin
         row_pos      = '0;
         cut_slot     = '0;
         next_cut     = '0;
         cut_quot     = '0;
         cut_rem      = '0;
         border_total = '0;
         last_border  = '0;
      end else begin
         row_pos = row_pos + IW'(1);
      end
      return beat;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatches < REPORT_CAP)
         $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: check each accepted beat against the oldest expectation, then pick the
   // next ready level. Both use the values from before the edge.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      bin_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_bins.size() == 0) begin
               report_mismatch("unexpected beat, row", rsp_row_index_res, 0);
            end else begin
               want = pending_bins.pop_front();
               if (rsp_row_index_res !== want.row_index)
                  report_mismatch("row_index_res", rsp_row_index_res, want.row_index);
               if (rsp_bin !== want.bin)
                  report_mismatch("bin", rsp_bin, want.bin);
               if (rsp_new_border !== want.new_border)
                  report_mismatch("new_border", rsp_new_border, want.new_border);
               if (rsp_border_value !== want.border_value)
                  report_mismatch("border_value", rsp_border_value, want.border_value);
               if (rsp_border_count !== want.border_count)
                  report_mismatch("border_count", rsp_border_count, want.border_count);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
               if (want.last)
                  passes_seen++;
               if (want.new_border)
                  borders_seen++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input side.
   // ---------------------------------------------------------------------------------------

   // Present one sorted value and hold it until accepted; queue what it should produce.
   // Valid is left high on return so back-to-back rows need no gap.
   task automatic send_row(input logic signed [VW-1:0] v, input logic [IW-1:0] r,
                           input bit typed, input bin_beat_type typed_beat);
      bin_beat_type predicted;
      if (req_high && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_high = 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end else if (!req_high) begin
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= v;
      req_row_index <= r;
      req_high = 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = bin_row(v, r);
      pending_bins.push_back(typed ? typed_beat : predicted);
      rows_sent++;
   endtask

   // Drop valid and wait until every expected beat has come back: the block is then idle.
   task automatic hold_off();
      if (req_high) begin
         req_valid <= 1'b0;
         req_high = 1'b0;
         @(posedge clock);
      end
      while (pending_bins.size() != 0) @(posedge clock);
   endtask

   // Call only while idle.
   task automatic write_csr(input logic [XW-1:0] sel, input logic [CW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      if (sel == qfb_pkg::CSR_COL_ROWS)
         cfg_rows = data[IW-1:0];
      else
         cfg_bin_limit = data[BW-1:0];
      csr_we <= 1'b0;
      csr_writes++;
      @(posedge clock);
   endtask

   function automatic plan_step_type plan_row(input logic signed [VW-1:0] v,
                                              input logic [IW-1:0] r,
                                              input bit typed, input bin_beat_type beat);
      plan_step_type s;
      s = '0;
      s.kind      = STEP_ROW;
      s.value     = v;
      s.row_index = r;
      s.typed     = typed;
      s.beat      = beat;
      return s;
   endfunction

   function automatic plan_step_type plan_csr(input logic [XW-1:0] sel,
                                              input logic [CW-1:0] data);
      plan_step_type s;
      s = '0;
      s.kind     = STEP_CSR;
      s.csr_sel  = sel;
      s.csr_data = data;
      return s;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus: directed table, then four random phases of column passes.
   // ---------------------------------------------------------------------------------------
   initial begin
      plan_step_type plan[$];
      int         idle_tab[4];
      int         stall_tab[4];
      int         phase;
      int         phase_rows;
      int         pick;
      int         n_rows;
      int         k;
      int         sel;
      bit         noisy;
      longint     cur;
      logic signed [VW-1:0] v;

      idle_tab  = '{0, 84, 0, 30};
      stall_tab = '{0, 0, 84, 30};

      // After reset one row, one bin: every row is its own border and ends the pass.
      plan.push_back(plan_row(32'sh8000_0000, 24'h000000, 1'b1,
                              '{24'h000000, 16'd0, 1'b1, 32'sh8000_0000, 16'd1, 1'b1}));
      // A zero row count behaves as one.
      plan.push_back(plan_csr(qfb_pkg::CSR_COL_ROWS, '0));
      plan.push_back(plan_row(32'sh7FFF_FFFF, 24'hFFFFFF, 1'b1,
                              '{24'hFFFFFF, 16'd0, 1'b1, 32'sh7FFF_FFFF, 16'd1, 1'b1}));
      // A zero bin limit behaves as one.
      plan.push_back(plan_csr(qfb_pkg::CSR_BIN_LIMIT, '0));
      plan.push_back(plan_row(32'sd0, 24'h00007B, 1'b1,
                              '{24'h00007B, 16'd0, 1'b1, 32'sd0, 16'd1, 1'b1}));
      // Single bin across three rows: border on the final row only.
      plan.push_back(plan_csr(qfb_pkg::CSR_COL_ROWS, 24'd3));
      plan.push_back(plan_row(32'sd5, 24'h000010, 1'b0, '0));
      plan.push_back(plan_row(32'sd5, 24'h000011, 1'b0, '0));
      plan.push_back(plan_row(32'sd7, 24'h000012, 1'b0, '0));
      // Largest bin limit, clipped to five rows; repeated values fold onto the newest border.
      plan.push_back(plan_csr(qfb_pkg::CSR_COL_ROWS, 24'd5));
      plan.push_back(plan_csr(qfb_pkg::CSR_BIN_LIMIT, 24'h00FFFF));
      plan.push_back(plan_row(32'sd1, 24'h000020, 1'b0, '0));
      plan.push_back(plan_row(32'sd1, 24'h000021, 1'b0, '0));
      plan.push_back(plan_row(32'sd2, 24'h000022, 1'b0, '0));
      plan.push_back(plan_row(32'sd2, 24'h000023, 1'b0, '0));
      plan.push_back(plan_row(32'sd3, 24'h000024, 1'b0, '0));
      // Two bins with a remainder, values out of order.
      plan.push_back(plan_csr(qfb_pkg::CSR_COL_ROWS, 24'd7));
      plan.push_back(plan_csr(qfb_pkg::CSR_BIN_LIMIT, 24'd2));
      plan.push_back(plan_row(32'sd10, 24'h000030, 1'b0, '0));
      plan.push_back(plan_row(32'sd3,  24'h000031, 1'b0, '0));
      plan.push_back(plan_row(32'sd8,  24'h000032, 1'b0, '0));
      plan.push_back(plan_row(-32'sd4, 24'h000033, 1'b0, '0));
      plan.push_back(plan_row(32'sd8,  24'h000034, 1'b0, '0));
      plan.push_back(plan_row(32'sd8,  24'h000035, 1'b0, '0));
      plan.push_back(plan_row(32'sd20, 24'h000036, 1'b0, '0));
      // Largest row count, then shrink it mid-pass so the pass closes early
      // with the latched quotient and remainder.
      plan.push_back(plan_csr(qfb_pkg::CSR_COL_ROWS, 24'hFFFFFF));
      plan.push_back(plan_csr(qfb_pkg::CSR_BIN_LIMIT, 24'h00FFFF));
      plan.push_back(plan_row(-32'sd100, 24'h000040, 1'b0, '0));
      plan.push_back(plan_row(-32'sd100, 24'h000041, 1'b0, '0));
      plan.push_back(plan_row(32'sd55,   24'h000042, 1'b0, '0));
      plan.push_back(plan_csr(qfb_pkg::CSR_COL_ROWS, 24'd4));
      plan.push_back(plan_row(32'sd56,   24'h000043, 1'b0, '0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_CSR) begin
            hold_off();
            write_csr(plan[i].csr_sel, plan[i].csr_data);
         end else begin
            send_row(plan[i].value, plan[i].row_index, plan[i].typed, plan[i].beat);
         end
      end

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = idle_tab[phase];
         stall_pct     = stall_tab[phase];
         phase_rows    = 0;
         while (phase_rows < ROWS_PER_PHASE) begin
            // Reconfigure between passes now and then; otherwise run passes back to back.
            pick = $urandom_range(3);
            if (pick != 0)
               hold_off();
            if ((pick & 1) != 0) begin
               sel = $urandom_range(19);
               if (sel == 0)
                  n_rows = 0;
               else if (sel == 1)
                  n_rows = 1;
               else if (sel < 14)
                  n_rows = $urandom_range(24, 2);
               else if (sel < 19)
                  n_rows = $urandom_range(80, 25);
               else
                  n_rows = $urandom_range(250, 81);
               write_csr(qfb_pkg::CSR_COL_ROWS, CW'(n_rows));
            end
            if ((pick & 2) != 0) begin
               sel = $urandom_range(9);
               if (sel == 0)
                  n_rows = 0;
               else if (sel == 1)
                  n_rows = 16'hFFFF;
               else if (sel == 2)
                  n_rows = 1;
               else if (sel < 8)
                  n_rows = $urandom_range(12, 2);
               else if (sel == 8)
                  n_rows = $urandom_range(300, 13);
               else
                  n_rows = $urandom_range(16'hFFFF, 0);
               // upper data bits are outside the register: fill them with junk
               write_csr(qfb_pkg::CSR_BIN_LIMIT,
                         {8'($urandom_range(255)), 16'(n_rows)});
            end

            n_rows = int'(rows_live());
            noisy  = ($urandom_range(9) == 0);
            sel    = $urandom_range(3);
            if (sel == 0)
               cur = -64'sd2147483648;
            else if (sel == 1)
               cur = longint'($signed($urandom()));
            else if (sel == 2)
               cur = longint'($urandom_range(200)) - 100;
            else
               cur = 64'sd2147483647 - longint'($urandom_range(60));

            for (k = 0; k < n_rows; k++) begin
               if (noisy) begin
                  v = $urandom();
               end else begin
                  // Ascending with plenty of repeats; saturate at the top of the range.
                  if (k != 0) begin
                     sel = $urandom_range(9);
                     if (sel < 4)
                        cur = cur;
                     else if (sel < 8)
                        cur = cur + $urandom_range(4, 1);
                     else if (sel == 8)
                        cur = cur + $urandom_range(1000000, 1);
                     else
                        cur = cur + longint'($urandom());
                     if (cur > 64'sd2147483647)
                        cur = 64'sd2147483647;
                  end
                  v = cur[VW-1:0];
               end
               send_row(v, IW'($urandom()), 1'b0, '0);
            end
            phase_rows += n_rows;
         end
      end

      hold_off();
      repeat (TAIL_CYCLES) @(posedge clock);
      while (pending_bins.size() != 0) begin
         report_mismatch("missing beat, row", 0, pending_bins[0].row_index);
         void'(pending_bins.pop_front());
      end

      $display("Run covered %0d rows over %0d column passes, %0d distinct borders,",
               rows_sent, passes_seen, borders_seen);
      $display("%0d register writes, with idle and stall patterns on both channels.",
               csr_writes);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Run timed out with %0d beats outstanding", pending_bins.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* quantile_feature_binner.f */
src/qfb_pkg.sv
src/qfb_divider.sv
src/quantile_feature_binner.sv
src/qfb_checker.sv
test/tb_quantile_feature_binner.sv
